[rtl/cstrk_pkg.sv]
// ----------------------------------------------------------------------------
// cstrk_pkg
// Shared types and constants for the singleton cluster coverage tracker.
// ----------------------------------------------------------------------------
package cstrk_pkg;

   localparam int EDGE_W    = 16;
   localparam int MAP_DEPTH = 1 << EDGE_W;
   localparam int EDGE_SPAN = 65536;
   localparam int COUNT_W   = 17;
   localparam int EXEC_W    = 48;
   localparam int KIND_W    = 2;

   localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_EDGE,
      ST_RD_POP,
      ST_DONE,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic              covered;
      logic              singleton;
      logic [EDGE_W-1:0] leader;
   } edge_entry_type;

   localparam int ENTRY_W = $bits(edge_entry_type);

   typedef struct packed {
      logic              we;
      logic [EDGE_W-1:0] waddr;
      edge_entry_type    wdata;
      logic              re;
      logic [EDGE_W-1:0] raddr;
   } edge_req_type;

   typedef struct packed {
      logic               we;
      logic [EDGE_W-1:0]  waddr;
      logic [COUNT_W-1:0] wdata;
      logic               re;
      logic [EDGE_W-1:0]  raddr;
   } pop_req_type;

endpackage

[rtl/cstrk_ram.sv]
// ----------------------------------------------------------------------------
// cstrk_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cstrk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cstrk_ctrl.sv]
// ----------------------------------------------------------------------------
// cstrk_ctrl
// Sequencer: read-modify-write of edge marks and cluster population, totals,
// map clear sweep and the result register.
// ----------------------------------------------------------------------------
module cstrk_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cstrk_pkg::KIND_W-1:0]     req_kind,
   input  logic [cstrk_pkg::EDGE_W-1:0]     req_edge_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_changed,
   output logic                             rsp_new_edge,
   output logic [cstrk_pkg::COUNT_W-1:0]    rsp_covered_count,
   output logic [cstrk_pkg::COUNT_W-1:0]    rsp_singleton_count,
   output logic [cstrk_pkg::COUNT_W-1:0]    rsp_cluster_count,
   output logic [cstrk_pkg::EXEC_W-1:0]     rsp_exec_count,
   output cstrk_pkg::edge_req_type          edge_req,
   input  cstrk_pkg::edge_entry_type        edge_rdata,
   output cstrk_pkg::pop_req_type           pop_req,
   input  logic [cstrk_pkg::COUNT_W-1:0]    pop_rdata
);

   cstrk_pkg::state_type                state_ff, state_in;
   logic [cstrk_pkg::EDGE_W-1:0]        edge_ff, edge_in;
   logic [cstrk_pkg::EDGE_W-1:0]        victim_ff, victim_in;
   logic [cstrk_pkg::EDGE_W-1:0]        sweep_ff, sweep_in;
   logic [cstrk_pkg::EDGE_W-1:0]        leader_ff, leader_in;
   logic [cstrk_pkg::COUNT_W-1:0]       covered_ff, covered_in;
   logic [cstrk_pkg::COUNT_W-1:0]       single_ff, single_in;
   logic [cstrk_pkg::COUNT_W-1:0]       cluster_ff, cluster_in;
   logic [cstrk_pkg::COUNT_W-1:0]       run_new_ff, run_new_in;
   logic [cstrk_pkg::EXEC_W-1:0]        exec_ff, exec_in;
   logic                                pend_ff, pend_in;
   logic                                chg_ff, chg_in;
   logic                                fresh_ff, fresh_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_chg_ff, rsp_chg_in;
   logic                                rsp_fresh_ff, rsp_fresh_in;
   logic [cstrk_pkg::COUNT_W-1:0]       rsp_cov_ff, rsp_cov_in;
   logic [cstrk_pkg::COUNT_W-1:0]       rsp_single_ff, rsp_single_in;
   logic [cstrk_pkg::COUNT_W-1:0]       rsp_cluster_ff, rsp_cluster_in;
   logic [cstrk_pkg::EXEC_W-1:0]        rsp_exec_ff, rsp_exec_in;
   logic [cstrk_pkg::EDGE_W-1:0]        new_leader;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cstrk_pkg::ST_SWEEP;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         covered_ff   <= '0;
         single_ff    <= '0;
         cluster_ff   <= '0;
         run_new_ff   <= '0;
         leader_ff    <= '0;
         exec_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         covered_ff   <= covered_in;
         single_ff    <= single_in;
         cluster_ff   <= cluster_in;
         run_new_ff   <= run_new_in;
         leader_ff    <= leader_in;
         exec_ff      <= exec_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff        <= edge_in;
      victim_ff      <= victim_in;
      chg_ff         <= chg_in;
      fresh_ff       <= fresh_in;
      rsp_chg_ff     <= rsp_chg_in;
      rsp_fresh_ff   <= rsp_fresh_in;
      rsp_cov_ff     <= rsp_cov_in;
      rsp_single_ff  <= rsp_single_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_exec_ff    <= rsp_exec_in;
   end

   always_comb begin
      state_in       = state_ff;
      edge_in        = edge_ff;
      victim_in      = victim_ff;
      sweep_in       = sweep_ff;
      leader_in      = leader_ff;
      covered_in     = covered_ff;
      single_in      = single_ff;
      cluster_in     = cluster_ff;
      run_new_in     = run_new_ff;
      exec_in        = exec_ff;
      pend_in        = pend_ff;
      chg_in         = chg_ff;
      fresh_in       = fresh_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_chg_in     = rsp_chg_ff;
      rsp_fresh_in   = rsp_fresh_ff;
      rsp_cov_in     = rsp_cov_ff;
      rsp_single_in  = rsp_single_ff;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_exec_in    = rsp_exec_ff;
      req_ready      = 1'b0;
      edge_req       = '0;
      pop_req        = '0;
      new_leader     = (run_new_ff == '0) ? edge_ff : leader_ff;

      case (state_ff)
         cstrk_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               edge_in  = req_edge_index;
               chg_in   = 1'b0;
               fresh_in = 1'b0;
               state_in = cstrk_pkg::ST_DONE;
               case (req_kind)
                  cstrk_pkg::KIND_HIT: begin
                     if (32'(req_edge_index) < cstrk_pkg::EDGE_SPAN) begin
                        edge_req.re    = 1'b1;
                        edge_req.raddr = req_edge_index;
                        state_in       = cstrk_pkg::ST_RD_EDGE;
                     end
                  end
                  cstrk_pkg::KIND_END: begin
                     if (exec_ff != '1) begin
                        exec_in = exec_ff + 1'b1;
                     end
                     if (run_new_ff != '0) begin
                        cluster_in = cluster_ff + 1'b1;
                     end
                     run_new_in = '0;
                  end
                  cstrk_pkg::KIND_CLEAR: begin
                     covered_in = '0;
                     single_in  = '0;
                     cluster_in = '0;
                     run_new_in = '0;
                     leader_in  = '0;
                     sweep_in   = '0;
                     pend_in    = 1'b1;
                     state_in   = cstrk_pkg::ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         cstrk_pkg::ST_RD_EDGE: begin
            state_in = cstrk_pkg::ST_DONE;
            if (!edge_rdata.covered) begin
               edge_req.we               = 1'b1;
               edge_req.waddr            = edge_ff;
               edge_req.wdata.covered    = 1'b1;
               edge_req.wdata.singleton  = 1'b1;
               edge_req.wdata.leader     = new_leader;
               // open cluster population tracks the run's new-edge count
               pop_req.we    = 1'b1;
               pop_req.waddr = new_leader;
               pop_req.wdata = run_new_ff + 1'b1;
               leader_in     = new_leader;
               run_new_in    = run_new_ff + 1'b1;
               covered_in    = covered_ff + 1'b1;
               single_in     = single_ff + 1'b1;
               chg_in        = 1'b1;
               fresh_in      = 1'b1;
            end else if (edge_rdata.singleton) begin
               edge_req.we               = 1'b1;
               edge_req.waddr            = edge_ff;
               edge_req.wdata.covered    = 1'b1;
               edge_req.wdata.singleton  = 1'b0;
               edge_req.wdata.leader     = edge_rdata.leader;
               pop_req.re    = 1'b1;
               pop_req.raddr = edge_rdata.leader;
               victim_in     = edge_rdata.leader;
               if (single_ff != '0) begin
                  single_in = single_ff - 1'b1;
               end
               chg_in   = 1'b1;
               state_in = cstrk_pkg::ST_RD_POP;
            end
         end
         cstrk_pkg::ST_RD_POP: begin
            state_in = cstrk_pkg::ST_DONE;
            if (pop_rdata != '0) begin
               pop_req.we    = 1'b1;
               pop_req.waddr = victim_ff;
               pop_req.wdata = pop_rdata - 1'b1;
               if (run_new_ff != '0 && victim_ff == leader_ff) begin
                  run_new_in = run_new_ff - 1'b1;
               end else if (pop_rdata == 17'd1 && cluster_ff != '0) begin
                  cluster_in = cluster_ff - 1'b1;
               end
            end
         end
         cstrk_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_chg_in     = chg_ff;
               rsp_fresh_in   = fresh_ff;
               rsp_cov_in     = covered_ff;
               rsp_single_in  = single_ff;
               rsp_cluster_in = cluster_ff;
               rsp_exec_in    = exec_ff;
               state_in       = cstrk_pkg::ST_IDLE;
            end
         end
         cstrk_pkg::ST_SWEEP: begin
            edge_req.we    = 1'b1;
            edge_req.waddr = sweep_ff;
            edge_req.wdata = '0;
            sweep_in       = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               pend_in  = 1'b0;
               state_in = pend_ff ? cstrk_pkg::ST_DONE : cstrk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cstrk_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_changed         = rsp_chg_ff;
   assign rsp_new_edge        = rsp_fresh_ff;
   assign rsp_covered_count   = rsp_cov_ff;
   assign rsp_singleton_count = rsp_single_ff;
   assign rsp_cluster_count   = rsp_cluster_ff;
   assign rsp_exec_count      = rsp_exec_ff;

endmodule

[rtl/coverage_singleton_cluster_tracker.sv]
// ----------------------------------------------------------------------------
// coverage_singleton_cluster_tracker
// A hit reads the edge-mark RAM in ST_RD_EDGE, a singleton loss then the
// population RAM in ST_RD_POP; each ends in ST_DONE, which loads the result.
// End-of-run and unused kinds go straight to ST_DONE, clear via ST_SWEEP. One
// item at a time, next beat taken the cycle after the result loads.
// Reset and clear sweep the 65536-entry edge RAM, one entry per cycle.
// ----------------------------------------------------------------------------
module coverage_singleton_cluster_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cstrk_pkg::KIND_W-1:0]     req_kind,
   input  logic [cstrk_pkg::EDGE_W-1:0]     req_edge_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_changed,
   output logic                             rsp_new_edge,
   output logic [cstrk_pkg::COUNT_W-1:0]    rsp_covered_count,
   output logic [cstrk_pkg::COUNT_W-1:0]    rsp_singleton_count,
   output logic [cstrk_pkg::COUNT_W-1:0]    rsp_cluster_count,
   output logic [cstrk_pkg::EXEC_W-1:0]     rsp_exec_count
);

   cstrk_pkg::edge_req_type          edge_req;
   cstrk_pkg::edge_entry_type        edge_rdata;
   cstrk_pkg::pop_req_type           pop_req;
   logic [cstrk_pkg::COUNT_W-1:0]    pop_rdata;
   logic [cstrk_pkg::ENTRY_W-1:0]    edge_rdata_raw;

   cstrk_ram #(
      .WIDTH (cstrk_pkg::ENTRY_W),
      .DEPTH (cstrk_pkg::MAP_DEPTH)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_req.we),
      .wr_addr (edge_req.waddr),
      .wr_data (edge_req.wdata),
      .rd_en   (edge_req.re),
      .rd_addr (edge_req.raddr),
      .rd_data (edge_rdata_raw)
   );

   assign edge_rdata = edge_rdata_raw;

   cstrk_ram #(
      .WIDTH (cstrk_pkg::COUNT_W),
      .DEPTH (cstrk_pkg::MAP_DEPTH)
   ) u_pop_ram (
      .clock   (clock),
      .wr_en   (pop_req.we),
      .wr_addr (pop_req.waddr),
      .wr_data (pop_req.wdata),
      .rd_en   (pop_req.re),
      .rd_addr (pop_req.raddr),
      .rd_data (pop_rdata)
   );

   cstrk_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_edge_index      (req_edge_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_changed         (rsp_changed),
      .rsp_new_edge        (rsp_new_edge),
      .rsp_covered_count   (rsp_covered_count),
      .rsp_singleton_count (rsp_singleton_count),
      .rsp_cluster_count   (rsp_cluster_count),
      .rsp_exec_count      (rsp_exec_count),
      .edge_req            (edge_req),
      .edge_rdata          (edge_rdata),
      .pop_req             (pop_req),
      .pop_rdata           (pop_rdata)
   );

   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("req_ready high during post-reset sweep");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("beat accepted while previous item in flight");

   a_new_implies_changed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_edge) |-> rsp_changed)
      else $error("new_edge without changed");

   a_single_le_covered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_singleton_count <= rsp_covered_count))
      else $error("singleton count exceeds covered count");

endmodule
